@@ rtl/lobm_pkg.sv @@
// lobm_pkg: shared types for the limit order book matcher.
// No dependencies.
`timescale 1ns / 1ps

package lobm_pkg;

    // Per-cycle command broadcast to every book cell.
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_POP    = 2'd2,
        CMD_DEC    = 2'd3
    } cell_cmd_t;

endpackage

@@ rtl/lobm_cell.sv @@
// lobm_cell: one slot of a sorted order book (price, quantity, valid).
// Uses lobm_pkg. Exchanges entries with its left and right neighbors.
`timescale 1ns / 1ps

module lobm_cell
    import lobm_pkg::*;
#(
    parameter int PRICE_BITS = 24,
    parameter int QTY_BITS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_cmd_t             cmd,
    input  logic                  is_buy_book,
    input  logic                  is_head,
    input  logic [PRICE_BITS-1:0] new_price,
    input  logic [QTY_BITS-1:0]   new_qty,
    input  logic [QTY_BITS-1:0]   dec_qty,
    // left neighbor (better priced)
    input  logic                  left_valid,
    input  logic                  left_ins_here,
    input  logic [PRICE_BITS-1:0] left_price,
    input  logic [QTY_BITS-1:0]   left_qty,
    // right neighbor
    input  logic                  right_valid,
    input  logic [PRICE_BITS-1:0] right_price,
    input  logic [QTY_BITS-1:0]   right_qty,
    output logic                  valid,
    output logic                  ins_here,
    output logic [PRICE_BITS-1:0] price,
    output logic [QTY_BITS-1:0]   qty
);

    logic                  valid_reg, valid_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_BITS-1:0]   qty_reg,   qty_next;
    logic                  beats;

    // New order goes ahead of this entry when strictly better priced.
    assign beats    = is_buy_book ? (new_price > price_reg) : (new_price < price_reg);
    assign ins_here = !valid_reg || beats;

    always_comb begin
        valid_next = valid_reg;
        price_next = price_reg;
        qty_next   = qty_reg;
        case (cmd)
            CMD_INSERT: begin
                if (ins_here && !left_ins_here) begin
                    valid_next = 1'b1;
                    price_next = new_price;
                    qty_next   = new_qty;
                end else if (ins_here && left_ins_here) begin
                    valid_next = left_valid;
                    price_next = left_price;
                    qty_next   = left_qty;
                end
            end
            CMD_POP: begin
                valid_next = right_valid;
                price_next = right_price;
                qty_next   = right_qty;
            end
            CMD_DEC: begin
                if (is_head) qty_next = qty_reg - dec_qty;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

    assign valid = valid_reg;
    assign price = price_reg;
    assign qty   = qty_reg;

endmodule

@@ rtl/lobm_book.sv @@
// lobm_book: one sorted book built as a chain of lobm_cell slots.
// Uses lobm_pkg and lobm_cell.
`timescale 1ns / 1ps

module lobm_book
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = 64,
    parameter int PRICE_BITS = 24,
    parameter int QTY_BITS   = 16,
    parameter bit IS_BUY     = 1'b1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_cmd_t             cmd,
    input  logic [PRICE_BITS-1:0] new_price,
    input  logic [QTY_BITS-1:0]   new_qty,
    input  logic [QTY_BITS-1:0]   dec_qty,
    output logic                  head_valid,
    output logic [PRICE_BITS-1:0] head_price,
    output logic [QTY_BITS-1:0]   head_qty,
    output logic [$clog2(BOOK_DEPTH+1)-1:0] count
);

    localparam int CW = $clog2(BOOK_DEPTH+1);

    logic [BOOK_DEPTH-1:0]                 v, ins;
    logic [BOOK_DEPTH-1:0][PRICE_BITS-1:0] p;
    logic [BOOK_DEPTH-1:0][QTY_BITS-1:0]   q;
    logic [CW-1:0] count_reg, count_next;

    for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
        lobm_cell #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd           (cmd),
            .is_buy_book   (IS_BUY),
            .is_head       (i == 0),
            .new_price     (new_price),
            .new_qty       (new_qty),
            .dec_qty       (dec_qty),
            .left_valid    ((i == 0) ? 1'b0 : v[(i == 0) ? 0 : i-1]),
            .left_ins_here ((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i-1]),
            .left_price    (p[(i == 0) ? 0 : i-1]),
            .left_qty      (q[(i == 0) ? 0 : i-1]),
            .right_valid   ((i == BOOK_DEPTH-1) ? 1'b0 : v[(i == BOOK_DEPTH-1) ? i : i+1]),
            .right_price   (p[(i == BOOK_DEPTH-1) ? i : i+1]),
            .right_qty     (q[(i == BOOK_DEPTH-1) ? i : i+1]),
            .valid         (v[i]),
            .ins_here      (ins[i]),
            .price         (p[i]),
            .qty           (q[i])
        );
    end

    // Entry count tracks the chain fill.
    always_comb begin
        count_next = count_reg;
        case (cmd)
            CMD_INSERT: count_next = count_reg + CW'(1);
            CMD_POP:    count_next = count_reg - CW'(1);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) count_reg <= '0;
        else          count_reg <= count_next;
    end

    assign head_valid = v[0];
    assign head_price = p[0];
    assign head_qty   = q[0];
    assign count      = count_reg;

    // Head valid agrees with a nonzero count.
    a_head_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid == (count_reg != '0)) else $error("head valid vs count");
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(BOOK_DEPTH)) else $error("book count overflow");
    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == CMD_POP |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not shrink book");

endmodule

@@ rtl/limit_order_book_matcher_unit.sv @@
// Limit order book matcher: each accepted request is matched against the head of
// the opposite book one fill per cycle, then any remainder is inserted into its own
// book by a parallel shift of the cell chain, unless that book is full. The time
// from an order's acceptance to the earliest next acceptance is bounded by the
// one-fill-per-cycle matching loop at the head cell. The result is registered in
// the done state; a result not yet taken by m_ready holds the next order in the
// done state. One order is in work at a time.
// Depends on lobm_pkg and lobm_book.
`timescale 1ns / 1ps

module limit_order_book_matcher_unit
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = 64,
    parameter int PRICE_BITS = 24,
    parameter int QTY_BITS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PRICE_BITS-1:0] s_price_ticks,
    input  logic [QTY_BITS-1:0]   s_quantity,
    input  logic                  s_side_buy,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_filled_quantity,
    output logic [6:0]            m_buy_count,
    output logic [6:0]            m_sell_count,
    output logic                  m_book_full
);

    localparam int CW = $clog2(BOOK_DEPTH+1);

    typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_DONE} state_t;

    state_t                state_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [QTY_BITS-1:0]   qty_reg;
    logic                  buy_reg;
    logic [QTY_BITS-1:0]   filled_reg;
    logic                  full_reg;
    logic                  m_valid_reg;
    logic [15:0]           m_filled_reg;
    logic [6:0]            m_buy_reg, m_sell_reg;
    logic                  m_full_reg;

    cell_cmd_t             bid_cmd, ask_cmd;
    logic                  bid_hv, ask_hv;
    logic [PRICE_BITS-1:0] bid_hp, ask_hp, opp_p;
    logic [QTY_BITS-1:0]   bid_hq, ask_hq, opp_q, fill;
    logic [CW-1:0]         bid_cnt, ask_cnt, own_cnt;
    logic                  opp_v, crosses, own_full;

    lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS),
                .QTY_BITS(QTY_BITS), .IS_BUY(1'b1)) u_bid (
        .aclk(aclk), .aresetn(aresetn), .cmd(bid_cmd),
        .new_price(price_reg), .new_qty(qty_reg), .dec_qty(fill),
        .head_valid(bid_hv), .head_price(bid_hp), .head_qty(bid_hq), .count(bid_cnt));

    lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS),
                .QTY_BITS(QTY_BITS), .IS_BUY(1'b0)) u_ask (
        .aclk(aclk), .aresetn(aresetn), .cmd(ask_cmd),
        .new_price(price_reg), .new_qty(qty_reg), .dec_qty(fill),
        .head_valid(ask_hv), .head_price(ask_hp), .head_qty(ask_hq), .count(ask_cnt));

    // Opposite head and crossing test.
    assign opp_v    = buy_reg ? ask_hv : bid_hv;
    assign opp_p    = buy_reg ? ask_hp : bid_hp;
    assign opp_q    = buy_reg ? ask_hq : bid_hq;
    assign own_cnt  = buy_reg ? bid_cnt : ask_cnt;
    assign own_full = (own_cnt >= CW'(BOOK_DEPTH));
    assign crosses  = opp_v && (buy_reg ? (price_reg >= opp_p) : (opp_p >= price_reg));
    assign fill     = (qty_reg < opp_q) ? qty_reg : opp_q;

    // Book commands for this cycle.
    always_comb begin
        bid_cmd = CMD_HOLD;
        ask_cmd = CMD_HOLD;
        if (state_reg == ST_MATCH && qty_reg != '0) begin
            if (crosses) begin
                if (buy_reg) ask_cmd = (fill == opp_q) ? CMD_POP : CMD_DEC;
                else         bid_cmd = (fill == opp_q) ? CMD_POP : CMD_DEC;
            end else if (!own_full) begin
                if (buy_reg) bid_cmd = CMD_INSERT;
                else         ask_cmd = CMD_INSERT;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer with registered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Result valid: set when a finished order loads, cleared once taken.
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        price_reg  <= s_price_ticks;
                        qty_reg    <= s_quantity;
                        buy_reg    <= s_side_buy;
                        filled_reg <= '0;
                        full_reg   <= 1'b0;
                        state_reg  <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    if (qty_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else if (crosses) begin
                        qty_reg    <= qty_reg - fill;
                        filled_reg <= filled_reg + fill;
                    end else begin
                        full_reg  <= own_full;
                        qty_reg   <= '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_filled_reg <= 16'(filled_reg);
                        m_buy_reg    <= 7'(bid_cnt);
                        m_sell_reg   <= 7'(ask_cnt);
                        m_full_reg   <= full_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_filled_quantity = m_filled_reg;
    assign m_buy_count       = m_buy_reg;
    assign m_sell_count      = m_sell_reg;
    assign m_book_full       = m_full_reg;

    // Books never stay crossed between orders.
    a_not_crossed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && bid_hv && ask_hv) |-> bid_hp < ask_hp)
        else $error("books crossed");
    a_one_book: assert property (@(posedge aclk) disable iff (!aresetn)
        !(bid_cmd != CMD_HOLD && ask_cmd != CMD_HOLD)) else $error("both books driven");
    a_fill_le: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MATCH && crosses && qty_reg != '0 |-> fill <= qty_reg)
        else $error("fill exceeds quantity");

endmodule
